>>> design/cfft_pkg.sv
package cfft_pkg;

    localparam int DefMaxPoints  = 64;
    localparam int DefSampleBits = 16;
    localparam int DefTwBits     = 16;
    localparam int WorkBits      = 24;
    localparam int OutBits       = 22;
    localparam int MaxLog2       = 6;

    typedef struct packed {
        logic load_we;
        logic bf_start;
        logic bf_step;
        logic swap_step;
        logic scale_step;
        logic emit_rd;
    } t_cmd;

    function automatic logic [23:0] qcos(input logic [4:0] k);
        logic [23:0] r;
        case (k)
            5'd0: r = 24'd8388607;
            5'd1: r = 24'd8348215;
            5'd2: r = 24'd8227423;
            5'd3: r = 24'd8027397;
            5'd4: r = 24'd7750063;
            5'd5: r = 24'd7398092;
            5'd6: r = 24'd6974873;
            5'd7: r = 24'd6484482;
            5'd8: r = 24'd5931642;
            5'd9: r = 24'd5321677;
            5'd10: r = 24'd4660461;
            5'd11: r = 24'd3954362;
            5'd12: r = 24'd3210181;
            5'd13: r = 24'd2435084;
            5'd14: r = 24'd1636536;
            5'd15: r = 24'd822227;
            default: r = 24'd0;
        endcase
        return r;
    endfunction

endpackage

>>> design/complex_fft_radix2.sv
// Channel | Direction | Handshake             | Payload
// input   | in        | i_in_valid/o_in_ready | i_sample_real, i_sample_imag
// output  | out       | o_out_valid/i_out_ready | o_bin_real, o_bin_imag, o_bin_last
// config  | in        | i_cfg_we              | i_cfg_index, i_cfg_wdata
// Samples are taken one per cycle while a frame loads.
// After the last sample the block swaps the frame into bit-reversed order, runs
// n/2*log2(n) butterflies through the two-port frame store and pipelined
// multiplier, then scales (inverse only) and emits bins, each bin waiting for
// i_out_ready.
// Reset is synchronous, active low.
module complex_fft_radix2 #(
    parameter int MAX_POINTS   = cfft_pkg::DefMaxPoints,
    parameter int SAMPLE_BITS  = cfft_pkg::DefSampleBits,
    parameter int TWIDDLE_BITS = cfft_pkg::DefTwBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [2:0]                    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [cfft_pkg::OutBits-1:0] o_bin_real,
    output logic signed [cfft_pkg::OutBits-1:0] o_bin_imag,
    output logic                          o_bin_last
);
    import cfft_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    logic [2:0] r_size_log2;
    logic       r_inverse;
    t_cmd       cmd;
    logic [AW-1:0] addr_a, addr_b;
    logic [4:0] tw_idx;
    logic [2:0] lg;
    logic       inv_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= 3'd6;
            r_inverse <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'b0) r_size_log2 <= i_cfg_wdata;
            else r_inverse <= i_cfg_wdata[0];
        end
    end

    cfft_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_size_log2(r_size_log2),
        .i_inverse(r_inverse),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_bin_last(o_bin_last), .o_cmd(cmd), .o_addr_a(addr_a),
        .o_addr_b(addr_b), .o_tw_idx(tw_idx), .o_lg(lg), .o_inv_scale(inv_mode)
    );

    cfft_datapath #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS),
                    .TWIDDLE_BITS(TWIDDLE_BITS), .AW(AW)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_addr_a(addr_a), .i_addr_b(addr_b),
        .i_tw_idx(tw_idx), .i_inverse(inv_mode), .i_lg(lg),
        .i_sample_real(i_sample_real), .i_sample_imag(i_sample_imag),
        .o_bin_real(o_bin_real), .o_bin_imag(o_bin_imag)
    );

endmodule

>>> design/cfft_datapath.sv
module cfft_datapath #(
    parameter int MAX_POINTS   = cfft_pkg::DefMaxPoints,
    parameter int SAMPLE_BITS  = cfft_pkg::DefSampleBits,
    parameter int TWIDDLE_BITS = cfft_pkg::DefTwBits,
    parameter int AW           = $clog2(MAX_POINTS)
) (
    input  logic                          i_clk,
    input  cfft_pkg::t_cmd                i_cmd,
    input  logic [AW-1:0]                 i_addr_a,
    input  logic [AW-1:0]                 i_addr_b,
    input  logic [4:0]                    i_tw_idx,
    input  logic                          i_inverse,
    input  logic [2:0]                    i_lg,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    output logic signed [cfft_pkg::OutBits-1:0] o_bin_real,
    output logic signed [cfft_pkg::OutBits-1:0] o_bin_imag
);
    import cfft_pkg::*;

    localparam int W  = WorkBits;
    localparam int TB = TWIDDLE_BITS;
    localparam int PB = W + TB + 2;

    logic signed [W-1:0] r_mem_re [MAX_POINTS];
    logic signed [W-1:0] r_mem_im [MAX_POINTS];
    logic signed [W-1:0] r_a_re, r_a_im, r_b_re, r_b_im;
    logic signed [TB-1:0] r_wr, r_wi;
    logic signed [PB-1:0] r_t_re, r_t_im;
    logic signed [W-1:0]  r_a2_re, r_a2_im;
    logic signed [TB-1:0] n_wr, n_wi;
    logic [23:0] c_raw, s_raw;
    logic signed [PB-1:0] p_re, p_im;
    logic signed [W+1:0] s0r, s0i, s1r, s1i;
    logic signed [W:0] sc_re, sc_im;
    logic signed [W:0] rnd;

    function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
        logic signed [W+1:0] hi, lo;
        hi = (W+2)'((64'sd1 <<< (W-1)) - 1);
        lo = -hi - 1;
        if (v > hi) return hi[W-1:0];
        if (v < lo) return lo[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic logic signed [TB-1:0] twr(input logic [23:0] m);
        logic [24:0] r;
        if (TB == 24) r = {1'b0, m};
        else r = ({1'b0, m} + (25'd1 << (23 - TB))) >> (24 - TB);
        if (r > ((25'd1 << (TB - 1)) - 25'd1)) r = (25'd1 << (TB - 1)) - 25'd1;
        return r[TB-1:0];
    endfunction

    always_comb begin
        logic signed [TB-1:0] c, s;
        if (i_tw_idx <= 5'd16) begin
            c_raw = qcos(i_tw_idx);
            s_raw = qcos(5'd16 - i_tw_idx);
            c = twr(c_raw);
        end else begin
            c_raw = qcos(5'd0 - i_tw_idx);
            s_raw = qcos(i_tw_idx - 5'd16);
            c = -twr(c_raw);
        end
        s = twr(s_raw);
        n_wr = c;
        n_wi = i_inverse ? s : -s;
    end

    assign p_re = PB'(r_b_re) * PB'(r_wr) - PB'(r_b_im) * PB'(r_wi)
                + (PB'(1) <<< (TB - 2));
    assign p_im = PB'(r_b_re) * PB'(r_wi) + PB'(r_b_im) * PB'(r_wr)
                + (PB'(1) <<< (TB - 2));

    always_comb begin
        logic signed [W+1:0] tr, ti;
        tr  = (W+2)'(r_t_re >>> (TB - 1));
        ti  = (W+2)'(r_t_im >>> (TB - 1));
        s0r = (W+2)'(r_a2_re) + tr;
        s0i = (W+2)'(r_a2_im) + ti;
        s1r = (W+2)'(r_a2_re) - tr;
        s1i = (W+2)'(r_a2_im) - ti;
    end

    assign rnd   = (W+1)'(1) << (i_lg - 3'd1);
    assign sc_re = ((W+1)'(r_a_re) + rnd) >>> i_lg;
    assign sc_im = ((W+1)'(r_a_im) + rnd) >>> i_lg;

    always_ff @(posedge i_clk) begin
        r_a_re <= r_mem_re[i_addr_a];
        r_a_im <= r_mem_im[i_addr_a];
        r_b_re <= r_mem_re[i_addr_b];
        r_b_im <= r_mem_im[i_addr_b];
        r_wr   <= n_wr;
        r_wi   <= n_wi;
        r_t_re <= p_re;
        r_t_im <= p_im;
        r_a2_re <= r_a_re;
        r_a2_im <= r_a_im;
        if (i_cmd.load_we) begin
            r_mem_re[i_addr_a] <= W'(i_sample_real);
            r_mem_im[i_addr_a] <= W'(i_sample_imag);
        end else if (i_cmd.bf_step) begin
            r_mem_re[i_addr_a] <= sat_w(s0r);
            r_mem_im[i_addr_a] <= sat_w(s0i);
            r_mem_re[i_addr_b] <= sat_w(s1r);
            r_mem_im[i_addr_b] <= sat_w(s1i);
        end else if (i_cmd.swap_step) begin
            r_mem_re[i_addr_a] <= r_b_re;
            r_mem_im[i_addr_a] <= r_b_im;
            r_mem_re[i_addr_b] <= r_a_re;
            r_mem_im[i_addr_b] <= r_a_im;
        end else if (i_cmd.scale_step) begin
            r_mem_re[i_addr_a] <= sc_re[W-1:0];
            r_mem_im[i_addr_a] <= sc_im[W-1:0];
        end
        if (i_cmd.emit_rd) begin
            o_bin_real <= (r_a_re > W'((1 <<< (OutBits-1)) - 1)) ? OutBits'((1 <<< (OutBits-1)) - 1)
                        : (r_a_re < -W'(1 <<< (OutBits-1))) ? OutBits'(-(1 <<< (OutBits-1)))
                        : r_a_re[OutBits-1:0];
            o_bin_imag <= (r_a_im > W'((1 <<< (OutBits-1)) - 1)) ? OutBits'((1 <<< (OutBits-1)) - 1)
                        : (r_a_im < -W'(1 <<< (OutBits-1))) ? OutBits'(-(1 <<< (OutBits-1)))
                        : r_a_im[OutBits-1:0];
        end
    end

    logic unused;
    assign unused = i_cmd.bf_start;

endmodule

>>> design/cfft_ctrl.sv
module cfft_ctrl #(
    parameter int MAX_POINTS = cfft_pkg::DefMaxPoints,
    parameter int AW         = $clog2(MAX_POINTS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [2:0]     i_size_log2,
    input  logic           i_inverse,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_bin_last,
    output cfft_pkg::t_cmd o_cmd,
    output logic [AW-1:0]  o_addr_a,
    output logic [AW-1:0]  o_addr_b,
    output logic [4:0]     o_tw_idx,
    output logic [2:0]     o_lg,
    output logic           o_inv_scale
);
    import cfft_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_SWAPR = 7'b0000010,
        S_SWAPW = 7'b0000100,
        S_BF    = 7'b0001000,
        S_SCALE = 7'b0010000,
        S_RD    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    localparam logic [2:0] MaxLg = 3'(AW);

    t_state r_state, n_state;
    logic [AW:0]   r_cnt, n_cnt;
    logic [2:0]    r_lg, n_lg, r_stage, n_stage;
    logic [1:0]    r_ph, n_ph;
    logic [AW:0]   r_idx, n_idx;
    logic          r_inv, n_inv;
    logic          r_last;
    logic [2:0]    cur_lg;
    logic [AW:0]   n_pts;
    logic [AW-1:0] rev, bf_a, bf_b;
    logic [AW-1:0] jmask;

    always_comb begin
        cur_lg = i_size_log2;
        if (cur_lg < 3'd1) cur_lg = 3'd1;
        if (cur_lg > MaxLg) cur_lg = MaxLg;
    end

    always_comb begin
        rev = '0;
        for (int b = 0; b < AW; b++)
            if (32'(b) < 32'(r_lg)) rev[32'(r_lg) - 1 - b] = r_idx[b];
    end

    always_comb begin
        logic [AW-1:0] k, m;
        k    = r_idx[AW-1:0];
        m    = AW'(1) << r_stage;
        jmask = m - AW'(1);
        bf_a = ((k & ~jmask) << 1) | (k & jmask);
        bf_b = bf_a | m;
        o_tw_idx = 5'((32'(k & jmask) << (5 - 32'(r_stage))));
    end

    assign n_pts = (AW+1)'(1) << r_lg;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_lg = r_lg;
        n_stage = r_stage;
        n_ph = r_ph;
        n_idx = r_idx;
        n_inv = r_inv;
        o_cmd = '0;
        o_addr_a = r_idx[AW-1:0];
        o_addr_b = rev;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_addr_a = (r_cnt < ((AW+1)'(1) << cur_lg)) ? r_cnt[AW-1:0]
                         : AW'(((AW+1)'(1) << cur_lg) - 1);
                if (i_in_valid) begin
                    o_cmd.load_we = 1'b1;
                    if ((AW+1)'(o_addr_a) + 1 < ((AW+1)'(1) << cur_lg)) begin
                        n_cnt = (AW+1)'(o_addr_a) + (AW+1)'(1);
                    end else begin
                        n_cnt = '0;
                        n_lg = cur_lg;
                        n_inv = i_inverse;
                        n_idx = '0;
                        n_state = S_SWAPR;
                    end
                end
            end
            S_SWAPR: begin
                if (r_idx[AW-1:0] < rev) n_state = S_SWAPW;
                else if (r_idx + 1 == n_pts) begin
                    n_idx = '0; n_stage = '0; n_ph = '0; n_state = S_BF;
                end else n_idx = r_idx + (AW+1)'(1);
            end
            S_SWAPW: begin
                o_cmd.swap_step = 1'b1;
                n_state = S_SWAPR;
                if (r_idx + 1 == n_pts) begin
                    n_idx = '0; n_stage = '0; n_ph = '0; n_state = S_BF;
                end else n_idx = r_idx + (AW+1)'(1);
            end
            S_BF: begin
                o_addr_a = bf_a;
                o_addr_b = bf_b;
                if (r_ph == 2'd3) begin
                    o_cmd.bf_step = 1'b1;
                    n_ph = '0;
                    if (r_idx + 1 == (n_pts >> 1)) begin
                        n_idx = '0;
                        if (r_stage + 1 == r_lg) begin
                            n_state = o_inv_scale ? S_SCALE : S_RD;
                            n_ph = '0;
                        end else n_stage = r_stage + 3'd1;
                    end else n_idx = r_idx + (AW+1)'(1);
                end else n_ph = r_ph + 2'd1;
            end
            S_SCALE: begin
                if (r_ph == 2'd1) begin
                    o_cmd.scale_step = 1'b1;
                    n_ph = '0;
                    if (r_idx + 1 == n_pts) begin n_idx = '0; n_state = S_RD; end
                    else n_idx = r_idx + (AW+1)'(1);
                end else n_ph = r_ph + 2'd1;
            end
            S_RD: begin
                if (r_ph == 2'd1) begin
                    o_cmd.emit_rd = 1'b1;
                    n_ph = '0;
                    n_state = S_OUT;
                end else n_ph = r_ph + 2'd1;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_last) begin n_idx = '0; n_state = S_LOAD; end
                    else begin n_idx = r_idx + (AW+1)'(1); n_state = S_RD; end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_bin_last  = r_last;
    assign o_lg        = r_lg;
    assign o_inv_scale = r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt <= '0;
            r_lg <= 3'd1;
            r_stage <= '0;
            r_ph <= '0;
            r_idx <= '0;
            r_inv <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_lg <= n_lg;
            r_stage <= n_stage;
            r_ph <= n_ph;
            r_idx <= n_idx;
            r_inv <= n_inv;
            if (o_cmd.emit_rd) r_last <= (r_idx + 1 == n_pts);
        end
    end

    a_ready_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_LOAD) else $error("ready outside load");
    a_valid_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("valid dropped");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < n_pts || r_state == S_LOAD) else $error("count out of range");

endmodule
